// ===== rtl/kpxbc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kpxbc_pkg
// Shared types and constants for the keyed permutation byte cipher.
// ----------------------------------------------------------------------------
package kpxbc_pkg;

    localparam int MAX_KEY_BYTES_DEF = 32;

    localparam int BYTE_W   = 8;
    localparam int TBL_AW   = 8;
    localparam int IDX_W    = 5;
    localparam int KLEN_W   = 6;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 64;
    localparam int WORD_BYTES = CFG_DW / BYTE_W;

    localparam logic [1:0] OP_INIT = 2'd0;
    localparam logic [1:0] OP_ENC  = 2'd1;
    localparam logic [1:0] OP_DEC  = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    localparam logic [CFG_AW-1:0] CFG_KEY_LENGTH = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_KEY_WORD0  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_KEY_WORD1  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_KEY_WORD2  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_KEY_WORD3  = 3'd4;

    typedef struct packed {
        logic [1:0]        op;
        logic [BYTE_W-1:0] data_in;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              status;
    } t_out_word;

endpackage
`default_nettype wire

// ===== rtl/kpxbc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kpxbc_ram
// 256 x 8 table memory, one write port, one registered read port.
// ----------------------------------------------------------------------------
module kpxbc_ram (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [kpxbc_pkg::TBL_AW-1:0] i_waddr,
    input  wire logic [kpxbc_pkg::BYTE_W-1:0] i_wdata,
    input  wire logic [kpxbc_pkg::TBL_AW-1:0] i_raddr,
    output logic      [kpxbc_pkg::BYTE_W-1:0] o_rdata
);
    import kpxbc_pkg::*;

    logic [BYTE_W-1:0] r_mem [2**TBL_AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/kpxbc_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kpxbc_step
// One keyed position step: maps a table position through the rotation
// that one key byte applies (below k right by one, above k left by one).
// ----------------------------------------------------------------------------
module kpxbc_step (
    input  wire logic [kpxbc_pkg::BYTE_W-1:0] i_key,
    input  wire logic [kpxbc_pkg::BYTE_W-1:0] i_pos,
    output logic      [kpxbc_pkg::BYTE_W-1:0] o_pos
);
    import kpxbc_pkg::*;

    localparam logic [BYTE_W-1:0] TOP = '1;

    always_comb begin
        if (i_pos == i_key) begin
            o_pos = i_pos;
        end else if (i_pos < i_key) begin
            o_pos = (i_pos == '0) ? i_key - 1'b1 : i_pos - 1'b1;
        end else begin
            o_pos = (i_pos == TOP) ? i_key + 1'b1 : i_pos + 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/keyed_permutation_xor_byte_cipher_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_permutation_xor_byte_cipher_unit
// Byte cipher with a keyed 256-entry permutation, built on init by a
// shared position step unit, then used for encrypt and decrypt lookups.
// ----------------------------------------------------------------------------
// channel  direction  handshake                 word
// in       sink       i_in_valid / o_in_stall   t_in_word  {op, data_in}
// out      source     o_out_valid / i_out_stall t_out_word {data_out, status}
// cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Encrypt/decrypt: one table read (registered memory port), result registered from S_LOOK.
// Passthrough, not-ready and NOP words: result registered directly from S_IDLE.
// Init: n = effective key length; the step unit applies one key byte per
// cycle to each of the 256 positions (no key byte when n is 0).
// Reset is synchronous; tables need no clearing since they are read
// only after an init. Output word holds while i_out_stall is high.
// ----------------------------------------------------------------------------
module keyed_permutation_xor_byte_cipher_unit #(
    parameter int MAX_KEY_BYTES = kpxbc_pkg::MAX_KEY_BYTES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire kpxbc_pkg::t_in_word          i_in,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output kpxbc_pkg::t_out_word              o_out,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [kpxbc_pkg::CFG_AW-1:0] i_cfg_index,
    input  wire logic [kpxbc_pkg::CFG_DW-1:0] i_cfg_data
);
    import kpxbc_pkg::*;

    localparam int KIW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [KLEN_W-1:0] MAXN = KLEN_W'(MAX_KEY_BYTES);
    localparam logic [TBL_AW-1:0] LAST = '1;

    typedef enum logic [1:0] {S_IDLE, S_BUILD, S_LOOK} t_state;

    t_state             r_state, n_state;
    logic [KLEN_W-1:0]  r_klen, n_klen;
    logic [BYTE_W-1:0]  r_key [MAX_KEY_BYTES];
    logic [IDX_W-1:0]   r_eidx, n_eidx, r_didx, n_didx, r_kidx, n_kidx;
    logic [TBL_AW-1:0]  r_addr, n_addr;
    logic [BYTE_W-1:0]  r_val, n_val, r_kb, n_kb;
    logic               r_is_dec, n_is_dec;
    logic               r_built, n_built;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out, n_out;

    logic [KLEN_W-1:0]  eff_n;
    logic               acc, cfg_wr;
    logic [IDX_W-1:0]   e_idx, d_idx, sel_idx;
    logic [BYTE_W-1:0]  kb_sel, kb_build, step_out, w_val;
    logic               w_en;
    logic [BYTE_W-1:0]  fwd_rdata, inv_rdata;

    function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx,
                                                    input logic [KLEN_W-1:0] n);
        logic [KLEN_W-1:0] v;
        v = (KLEN_W'(idx) >= n) ? '0 : KLEN_W'(idx);
        v = v + 1'b1;
        if (v >= n) begin
            v = '0;
        end
        return v[IDX_W-1:0];
    endfunction

    assign eff_n       = (r_klen > MAXN) ? MAXN : r_klen;
    assign o_in_stall  = !(r_state == S_IDLE && (!r_out_valid || !i_out_stall));
    assign o_cfg_ready = (r_state == S_IDLE);
    assign acc         = i_in_valid && !o_in_stall;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign e_idx   = (KLEN_W'(r_eidx) < eff_n) ? r_eidx : '0;
    assign d_idx   = (KLEN_W'(r_didx) < eff_n) ? r_didx : '0;
    assign sel_idx = (i_in.op == OP_DEC) ? d_idx : e_idx;

    always_comb begin
        kb_sel = '0;
        if (KLEN_W'(sel_idx) < MAXN) begin
            kb_sel = r_key[sel_idx[KIW-1:0]];
        end
    end

    always_comb begin
        kb_build = '0;
        if (KLEN_W'(r_kidx) < MAXN) begin
            kb_build = r_key[r_kidx[KIW-1:0]];
        end
    end

    kpxbc_step u_step (
        .i_key (kb_build),
        .i_pos (r_val),
        .o_pos (step_out)
    );

    assign w_en  = (r_state == S_BUILD) && (eff_n == '0 || r_kidx == '0);
    assign w_val = (eff_n == '0) ? r_val : step_out;

    kpxbc_ram u_fwd (
        .i_clk   (i_clk),
        .i_we    (w_en),
        .i_waddr (r_addr),
        .i_wdata (w_val),
        .i_raddr (i_in.data_in ^ kb_sel),
        .o_rdata (fwd_rdata)
    );

    kpxbc_ram u_inv (
        .i_clk   (i_clk),
        .i_we    (w_en),
        .i_waddr (w_val),
        .i_wdata (r_addr),
        .i_raddr (i_in.data_in),
        .o_rdata (inv_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_klen      = r_klen;
        n_eidx      = r_eidx;
        n_didx      = r_didx;
        n_kidx      = r_kidx;
        n_addr      = r_addr;
        n_val       = r_val;
        n_kb        = r_kb;
        n_is_dec    = r_is_dec;
        n_built     = r_built;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_KEY_LENGTH: begin
                    n_klen  = i_cfg_data[KLEN_W-1:0];
                    n_built = 1'b0;
                end
                CFG_KEY_WORD0, CFG_KEY_WORD1, CFG_KEY_WORD2, CFG_KEY_WORD3: begin
                    n_built = 1'b0;
                end
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    unique case (i_in.op)
                        OP_INIT: begin
                            n_state = S_BUILD;
                            n_eidx  = '0;
                            n_didx  = '0;
                            n_addr  = '0;
                            n_val   = '0;
                            n_kidx  = (eff_n == '0) ? '0 : IDX_W'(eff_n - 1'b1);
                        end
                        OP_NOP: begin
                            n_out_valid = 1'b1;
                            n_out       = '{data_out: '0, status: !r_built};
                        end
                        default: begin
                            if (eff_n == '0) begin
                                n_out_valid = 1'b1;
                                n_out       = '{data_out: i_in.data_in, status: 1'b0};
                            end else if (!r_built) begin
                                n_out_valid = 1'b1;
                                n_out       = '{data_out: '0, status: 1'b1};
                            end else begin
                                n_state  = S_LOOK;
                                n_is_dec = (i_in.op == OP_DEC);
                                n_kb     = kb_sel;
                                if (i_in.op == OP_DEC) begin
                                    n_didx = next_index(r_didx, eff_n);
                                end else begin
                                    n_eidx = next_index(r_eidx, eff_n);
                                end
                            end
                        end
                    endcase
                end
            end
            S_BUILD: begin
                if (w_en) begin
                    if (r_addr == LAST) begin
                        n_state     = S_IDLE;
                        n_built     = 1'b1;
                        n_out_valid = 1'b1;
                        n_out       = '{data_out: '0, status: 1'b0};
                    end else begin
                        n_addr = r_addr + 1'b1;
                        n_val  = r_addr + 1'b1;
                        n_kidx = (eff_n == '0) ? '0 : IDX_W'(eff_n - 1'b1);
                    end
                end else begin
                    n_val  = step_out;
                    n_kidx = r_kidx - 1'b1;
                end
            end
            S_LOOK: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_out       = '{data_out: r_is_dec ? (inv_rdata ^ r_kb) : fwd_rdata,
                                status: 1'b0};
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_klen      <= '0;
            r_eidx      <= '0;
            r_didx      <= '0;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int b = 0; b < MAX_KEY_BYTES; b++) begin
                r_key[b] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_klen      <= n_klen;
            r_eidx      <= n_eidx;
            r_didx      <= n_didx;
            r_built     <= n_built;
            r_out_valid <= n_out_valid;
            for (int b = 0; b < MAX_KEY_BYTES; b++) begin
                if (cfg_wr && i_cfg_index == CFG_AW'(int'(CFG_KEY_WORD0) + b / WORD_BYTES)) begin
                    r_key[b] <= i_cfg_data[(b % WORD_BYTES) * BYTE_W +: BYTE_W];
                end
            end
        end
        r_kidx   <= n_kidx;
        r_addr   <= n_addr;
        r_val    <= n_val;
        r_kb     <= n_kb;
        r_is_dec <= n_is_dec;
        r_out    <= n_out;
    end

    a_look_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOOK |-> !r_out_valid)
        else $error("lookup with output register occupied");

    a_enc_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_in.op == OP_ENC || i_in.op == OP_DEC) && r_built && eff_n != '0
        |=> r_state == S_LOOK && !r_out_valid)
        else $error("cipher word did not start a lookup");

    a_build_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BUILD && n_state == S_IDLE |=> r_built && r_out_valid)
        else $error("table build ended without result");

    a_no_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_cfg_ready && o_in_stall)
        else $error("ports open while busy");

endmodule
`default_nettype wire
